>>> hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects clk and rst_n (active low) in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/recd_pkg.sv
// Package for the rotary encoder click decoder: constants, codes and the
// front-to-back command type. No dependencies.
`default_nettype none

package recd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIMER_BITS_DEF  = 16;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd1000;

    // Command queue between front and back
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam int CNT_W = 8;
    localparam logic signed [CNT_W-1:0] CNT_MAX  = 8'sh7f;
    localparam logic signed [CNT_W-1:0] CNT_MIN  = 8'sh80;
    localparam logic signed [CNT_W-1:0] CNT_ONE  = 8'sh01;
    localparam logic signed [CNT_W-1:0] CNT_MONE = 8'shff;
    localparam logic signed [CNT_W-1:0] CNT_ZERO = 8'sh00;

    typedef enum logic {
        CMD_CLICK = 1'b0,
        CMD_POP   = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      dir;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/recd_in_if.sv
// Input channel of the decoder: valid/ready plus one sample or pop item.
// No dependencies.
`default_nettype none

interface recd_in_if;
    logic valid;
    logic ready;
    logic func;
    logic line_a_active;
    logic line_b_active;

    modport source (output valid, func, line_a_active, line_b_active, input ready);
    modport sink   (input valid, func, line_a_active, line_b_active, output ready);
endinterface

`default_nettype wire

>>> hdl/recd_out_if.sv
// Output channel of the decoder: valid/ready plus one click count result.
// No dependencies.
`default_nettype none

interface recd_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] click_count;
    logic              count_valid;

    modport source (output valid, click_count, count_valid, input ready);
    modport sink   (input valid, click_count, count_valid, output ready);
endinterface

`default_nettype wire

>>> hdl/recd_front.sv
// Front end: accepts items, debounces both lines, tracks direction and
// half clicks, and issues click/pop commands. Uses recd_pkg, recd_in_if.
`default_nettype none
`include "assert_macros.svh"

module recd_front #(
    parameter int TIMER_BITS = recd_pkg::TIMER_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [recd_pkg::CFG_W-1:0] cfg_wr_data,
    recd_in_if.sink                         in_ch,
    output logic                            cmd_valid,
    output recd_pkg::cmd_t                  cmd,
    input  wire logic                       cmd_ready
);

    localparam int TW = TIMER_BITS;
    localparam int CW = recd_pkg::CFG_W;

    typedef struct packed {
        logic dir_known;
        logic last_dir;
        logic last_trig_a;
        logic half;
    } cls_t;

    typedef struct packed {
        logic [TW-1:0] timer;
        logic          waiting;
        logic          fire;
    } line_res_t;

    typedef struct packed {
        cls_t st;
        logic click;
        logic dir;
    } evt_res_t;

    logic [CW-1:0] dbnc_reg;
    logic          prev_a_reg, prev_b_reg;
    logic [TW-1:0] timer_a_reg, timer_b_reg;
    logic          wait_a_reg, wait_b_reg;
    cls_t          cls_reg, cls_mid, cls_next;

    logic [TW-1:0] load_val;
    line_res_t     res_a, res_b;
    evt_res_t      ev_a, ev_b;
    logic          accept, is_tick, click_a, click_b;

    generate
        if (TW > CW) begin : g_load_wide
            assign load_val = {{(TW-CW){1'b0}}, dbnc_reg};
        end else if (TW == CW) begin : g_load_eq
            assign load_val = dbnc_reg;
        end else begin : g_load_sat
            localparam logic [CW-1:0] TMAX = CW'((1 << TW) - 1);
            assign load_val = (dbnc_reg > TMAX) ? TW'(TMAX) : dbnc_reg[TW-1:0];
        end
    endgenerate

    function automatic line_res_t line_tick(input logic level, input logic prev,
                                            input logic [TW-1:0] timer,
                                            input logic waiting,
                                            input logic [TW-1:0] load);
        line_res_t r;
        r.timer   = timer;
        r.waiting = waiting;
        r.fire    = 1'b0;
        if (level && !prev)
        begin
            r.timer   = load;
            r.waiting = 1'b1;
        end
        else if (waiting)
        begin
            if (timer <= TW'(1))
            begin
                r.timer   = '0;
                r.waiting = 1'b0;
                r.fire    = level;
            end
            else
            begin
                r.timer = timer - TW'(1);
            end
        end
        return r;
    endfunction

    // Direction change re-arms; alternating lines in one direction count halves.
    function automatic evt_res_t commit_event(input cls_t st, input logic trig_a,
                                              input logic other);
        evt_res_t r;
        logic     dir;
        dir     = (trig_a == other);
        r.st    = st;
        r.click = 1'b0;
        r.dir   = dir;
        if (!st.dir_known || (st.last_dir != dir))
        begin
            r.st.dir_known   = 1'b1;
            r.st.last_dir    = dir;
            r.st.last_trig_a = trig_a;
            r.st.half        = 1'b1;
        end
        else if (st.last_trig_a != trig_a)
        begin
            r.st.last_trig_a = trig_a;
            if (st.half)
            begin
                r.click   = 1'b1;
                r.st.half = 1'b0;
            end
            else
            begin
                r.st.half = 1'b1;
            end
        end
        return r;
    endfunction

    assign in_ch.ready = cmd_ready;
    assign accept      = in_ch.valid && cmd_ready;
    assign is_tick     = (in_ch.func == recd_pkg::FUNC_TICK);

    // Line A is handled first; line B sees the state A left behind.
    always_comb
    begin
        res_a    = line_tick(in_ch.line_a_active, prev_a_reg, timer_a_reg, wait_a_reg,
                             load_val);
        res_b    = line_tick(in_ch.line_b_active, prev_b_reg, timer_b_reg, wait_b_reg,
                             load_val);
        ev_a     = commit_event(cls_reg, 1'b1, in_ch.line_b_active);
        cls_mid  = res_a.fire ? ev_a.st : cls_reg;
        ev_b     = commit_event(cls_mid, 1'b0, in_ch.line_a_active);
        cls_next = res_b.fire ? ev_b.st : cls_mid;
        click_a  = res_a.fire && ev_a.click;
        click_b  = res_b.fire && ev_b.click;
    end

    // At most one click can come out of one tick.
    always_comb
    begin
        cmd.kind  = is_tick ? recd_pkg::CMD_CLICK : recd_pkg::CMD_POP;
        cmd.dir   = click_a ? ev_a.dir : ev_b.dir;
        cmd_valid = accept && (!is_tick || click_a || click_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbnc_reg <= recd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            dbnc_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg  <= 1'b0;
            prev_b_reg  <= 1'b0;
            timer_a_reg <= '0;
            timer_b_reg <= '0;
            wait_a_reg  <= 1'b0;
            wait_b_reg  <= 1'b0;
            cls_reg     <= '0;
        end
        else if (accept && is_tick)
        begin
            prev_a_reg  <= in_ch.line_a_active;
            prev_b_reg  <= in_ch.line_b_active;
            timer_a_reg <= res_a.timer;
            timer_b_reg <= res_b.timer;
            wait_a_reg  <= res_a.waiting;
            wait_b_reg  <= res_b.waiting;
            cls_reg     <= cls_next;
        end
    end

    `ASSERT_CLK(a_pop_holds_timers, (accept && !is_tick) |=> ($stable(timer_a_reg) && $stable(timer_b_reg) && $stable(cls_reg)), "pop item changed debounce state")

endmodule

`default_nettype wire

>>> hdl/recd_cmd_fifo.sv
// Short command queue between the front end and the click queue back end.
// Uses recd_pkg (command type, depth).
`default_nettype none
`include "assert_macros.svh"

module recd_cmd_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  recd_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output recd_pkg::cmd_t pop_cmd,
    input  wire logic      pop_ready
);

    localparam int DEPTH = recd_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    recd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             full_reg;
    logic             do_push, do_pop;

    assign push_ready = !full_reg;
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full_reg;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                full_reg <= (cnt_reg == CNT_W'(DEPTH - 1));
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                full_reg <= 1'b0;
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, push_valid && full_reg, "command pushed into full queue")
    `ASSERT_CLK(a_full_flag, full_reg == (cnt_reg == CNT_W'(DEPTH)), "full flag out of step with count")

endmodule

`default_nettype wire

>>> hdl/recd_back.sv
// Back end: click queue with merge/saturate and drop-oldest, pop reads
// and the output register. Uses recd_pkg, recd_out_if.
`default_nettype none
`include "assert_macros.svh"

module recd_back #(
    parameter int QUEUE_DEPTH = recd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  recd_pkg::cmd_t cmd,
    output logic           cmd_ready,
    recd_out_if.source     out_ch
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int VW    = recd_pkg::CNT_W;

    logic signed [VW-1:0] store_mem [QUEUE_DEPTH];
    logic signed [VW-1:0] rd_data_reg;
    logic                 resp_flag_reg, resp_valid_reg;
    logic [IDX_W-1:0]     head_reg, tail_reg, last_idx_reg;
    logic [QC_W-1:0]      cnt_reg;
    logic signed [VW-1:0] last_val_reg, last_val_next;

    logic             slot_free, do_cmd, do_pop, do_click;
    logic             empty, full, merge;
    logic [IDX_W-1:0] wr_addr, head_inc, tail_inc;

    assign slot_free = !resp_valid_reg || out_ch.ready;
    assign cmd_ready = (cmd.kind == recd_pkg::CMD_CLICK) || slot_free;
    assign do_cmd    = cmd_valid && cmd_ready;
    assign do_pop    = do_cmd && (cmd.kind == recd_pkg::CMD_POP);
    assign do_click  = do_cmd && (cmd.kind == recd_pkg::CMD_CLICK);

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == QC_W'(QUEUE_DEPTH));
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Newest entry is kept in a register, so a merge needs no memory read.
    assign merge   = !empty && ((last_val_reg > recd_pkg::CNT_ZERO) == cmd.dir);
    assign wr_addr = merge ? last_idx_reg : tail_reg;

    always_comb
    begin
        if (!merge)
        begin
            last_val_next = cmd.dir ? recd_pkg::CNT_ONE : recd_pkg::CNT_MONE;
        end
        else if (cmd.dir)
        begin
            last_val_next = (last_val_reg == recd_pkg::CNT_MAX) ? last_val_reg
                                                                  : last_val_reg + 8'sd1;
        end
        else
        begin
            last_val_next = (last_val_reg == recd_pkg::CNT_MIN) ? last_val_reg
                                                                  : last_val_reg - 8'sd1;
        end
    end

    assign out_ch.valid       = resp_valid_reg;
    assign out_ch.count_valid = resp_flag_reg;
    assign out_ch.click_count = resp_flag_reg ? rd_data_reg : recd_pkg::CNT_ZERO;

    always_ff @(posedge clk)
    begin
        if (do_click)
        begin
            store_mem[wr_addr] <= last_val_next;
            last_val_reg       <= last_val_next;
        end
        if (do_pop)
        begin
            rd_data_reg <= store_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            last_idx_reg   <= '0;
            cnt_reg        <= '0;
            resp_flag_reg  <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_click && !merge)
            begin
                tail_reg     <= tail_inc;
                last_idx_reg <= tail_reg;
                if (full)
                begin
                    head_reg <= head_inc; // drop oldest
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (do_pop && !empty)
            begin
                head_reg <= head_inc;
                cnt_reg  <= cnt_reg - 1'b1;
            end

            if (do_pop)
            begin
                resp_valid_reg <= 1'b1;
                resp_flag_reg  <= !empty;
            end
            else if (out_ch.ready)
            begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_cnt_bound, cnt_reg <= QC_W'(QUEUE_DEPTH), "click queue count over depth")
    `ASSERT_CLK(a_newest_nonzero, (cnt_reg != '0) |-> (last_val_reg != recd_pkg::CNT_ZERO), "newest entry holds zero")
    `ASSERT_CLK(a_pop_dec, (do_pop && !empty) |=> (cnt_reg == $past(cnt_reg) - 1'b1), "pop did not take an entry")

endmodule

`default_nettype wire

>>> hdl/rotary_encoder_click_decoder_top.sv
// Top level of the rotary encoder click decoder.
// Uses recd_pkg, recd_in_if, recd_out_if, recd_front, recd_cmd_fifo, recd_back.
//
// Usage:
//   in_ch carries one item per handshake (valid && ready): func = 0 is a sample
//   tick with both line levels, func = 1 pops the oldest click count.
//   out_ch returns one item per pop: click_count and count_valid (0 when the
//   click queue was empty). Ticks return nothing.
//   cfg_wr_en/cfg_wr_data write debounce_ticks (reset 1000); write only when idle.
//   Throughput: one item per cycle while the command queue has room. The front
//   end handles a tick in the cycle it is accepted; commands pass a 4-deep
//   queue to the back end, which does one click update or one pop read per
//   cycle (a pop waits while a result is held) on a single-port click
//   memory and an output register. When out_ch stalls, the held result stays
//   put, clicks behind a waiting pop stay in the command queue, and in_ch.ready
//   drops once that queue fills. Reset clears timers, direction state and the
//   click queue (empty); the click memory itself needs no clearing pass.
`default_nettype none

module rotary_encoder_click_decoder_top #(
    parameter int QUEUE_DEPTH = recd_pkg::QUEUE_DEPTH_DEF,
    parameter int TIMER_BITS  = recd_pkg::TIMER_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [recd_pkg::CFG_W-1:0] cfg_wr_data,
    recd_in_if.sink                         in_ch,
    recd_out_if.source                      out_ch
);

    logic           f_valid, f_ready;
    recd_pkg::cmd_t f_cmd;
    logic           b_valid, b_ready;
    recd_pkg::cmd_t b_cmd;

    recd_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .cmd_valid   (f_valid),
        .cmd         (f_cmd),
        .cmd_ready   (f_ready)
    );

    recd_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_cmd    (b_cmd),
        .pop_ready  (b_ready)
    );

    recd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd       (b_cmd),
        .cmd_ready (b_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for rotary_encoder_click_decoder_top: debounce, direction,
// click merging and saturation, queue overflow and pops, checked against a predictor.
// Depends on recd_pkg, recd_in_if, recd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int QDEPTH      = recd_pkg::QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [recd_pkg::CNT_W-1:0] count;
        logic                              flag;
    } click_res_t;

    typedef struct packed {
        logic                              func;
        logic                              line_a;
        logic                              line_b;
        logic                              typed;
        logic signed [recd_pkg::CNT_W-1:0] count;
        logic                              flag;
    } step_row_t;

    // Directed sequence at debounce 1; the typed rows are pops of an empty queue.
    localparam step_row_t DIRECTED [20] = '{
        '{recd_pkg::FUNC_POP,  1'b0, 1'b0, 1'b1, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_POP,  1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b0, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_POP,  1'b0, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_POP,  1'b1, 1'b0, 1'b1, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_TICK, 1'b1, 1'b1, 1'b0, recd_pkg::CNT_ZERO, 1'b0},
        '{recd_pkg::FUNC_POP,  1'b0, 1'b0, 1'b0, recd_pkg::CNT_ZERO, 1'b0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [recd_pkg::CFG_W-1:0] cfg_wr_data;

    recd_in_if  in_ch();
    recd_out_if out_ch();

    rotary_encoder_click_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // Decoder state as the predictor sees it
    logic [recd_pkg::CFG_W-1:0]        debounce_len;
    logic                              a_prev, b_prev, a_armed, b_armed;
    logic [15:0]                       a_timer, b_timer;
    logic                              dir_seen, dir_last, last_from_a, half_step;
    logic signed [recd_pkg::CNT_W-1:0] click_mem [QDEPTH];
    int                                q_head, q_tail, q_used;

    click_res_t pending_counts[$];
    step_row_t  typed_counts[$];

    int src_idle_pct, sink_stall_pct, pop_pct;
    int hold_left, quiet_cycles;
    int sent_items, accepted_items, pops_checked, fails, overflows;
    int max_seen, min_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void push_click(input logic signed [recd_pkg::CNT_W-1:0] v);
        if (q_used >= QDEPTH)
        begin
            q_head = (q_head + 1) % QDEPTH;
            q_used--;
            overflows++;
        end
        click_mem[q_tail] = v;
        q_tail = (q_tail + 1) % QDEPTH;
        q_used++;
    endfunction

    function automatic void add_click(input logic d);
        int                                newest;
        logic signed [recd_pkg::CNT_W-1:0] cur;
        if (q_used == 0)
        begin
            push_click(d ? recd_pkg::CNT_ONE : recd_pkg::CNT_MONE);
        end
        else
        begin
            newest = (q_tail + QDEPTH - 1) % QDEPTH;
            cur = click_mem[newest];
            if ((cur > recd_pkg::CNT_ZERO) == d)
            begin
                if (d && cur != recd_pkg::CNT_MAX)
                    click_mem[newest] = cur + recd_pkg::CNT_ONE;
                else if (!d && cur != recd_pkg::CNT_MIN)
                    click_mem[newest] = cur - recd_pkg::CNT_ONE;
            end
            else
            begin
                push_click(d ? recd_pkg::CNT_ONE : recd_pkg::CNT_MONE);
            end
        end
    endfunction

    function automatic void apply_event(input logic from_a, input logic other_lvl);
        logic d;
        d = (from_a == other_lvl);
        if (!dir_seen || dir_last != d)
        begin
            // direction change re-arms, no click
            dir_seen    = 1'b1;
            dir_last    = d;
            last_from_a = from_a;
            half_step   = 1'b1;
        end
        else if (last_from_a != from_a)
        begin
            last_from_a = from_a;
            if (half_step)
            begin
                add_click(d);
                half_step = 1'b0;
            end
            else
            begin
                half_step = 1'b1;
            end
        end
    endfunction

    function automatic logic debounce_step(input logic lvl, inout logic prev,
                                           inout logic [15:0] tmr, inout logic armed);
        logic fire;
        fire = 1'b0;
        if (lvl && !prev)
        begin
            tmr   = debounce_len;
            armed = 1'b1;
        end
        else if (armed)
        begin
            // a load of 0 expires on the next tick, same as 1
            if (tmr <= 16'd1)
            begin
                tmr   = '0;
                armed = 1'b0;
                fire  = lvl;
            end
            else
            begin
                tmr = tmr - 16'd1;
            end
        end
        prev = lvl;
        return fire;
    endfunction

    // Returns 1 when the item yields a result, placed in r.
    function automatic logic predict_item(input logic f, input logic la, input logic lb,
                                          output click_res_t r);
        r = '{count: recd_pkg::CNT_ZERO, flag: 1'b0};
        if (f == recd_pkg::FUNC_POP)
        begin
            if (q_used != 0)
            begin
                r.count = click_mem[q_head];
                r.flag  = 1'b1;
                q_head  = (q_head + 1) % QDEPTH;
                q_used--;
            end
            return 1'b1;
        end
        if (debounce_step(la, a_prev, a_timer, a_armed))
            apply_event(1'b1, lb);
        if (debounce_step(lb, b_prev, b_timer, b_armed))
            apply_event(1'b0, la);
        return 1'b0;
    endfunction

    // Both handshakes sampled at the edge; results first, since a pop never
    // returns in the cycle it is accepted.
    always @(posedge clk)
    begin : monitor
        click_res_t want;
        click_res_t pred;
        step_row_t  row;
        logic       out_acc, in_acc;
        out_acc = out_ch.valid && out_ch.ready;
        in_acc  = in_ch.valid && in_ch.ready;
        if (rst_n && out_acc)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("unexpected result: click_count %0d count_valid %0b",
                       out_ch.click_count, out_ch.count_valid);
                fails++;
            end
            else
            begin
                want = pending_counts.pop_front();
                pops_checked++;
                if (out_ch.click_count !== want.count)
                begin
                    $error("click_count: expected %0d, got %0d", want.count,
                           out_ch.click_count);
                    fails++;
                end
                if (out_ch.count_valid !== want.flag)
                begin
                    $error("count_valid: expected %0b, got %0b", want.flag,
                           out_ch.count_valid);
                    fails++;
                end
                if (want.flag && int'(want.count) > max_seen) max_seen = want.count;
                if (want.flag && int'(want.count) < min_seen) min_seen = want.count;
            end
        end
        if (rst_n && in_acc)
        begin
            accepted_items++;
            if (predict_item(in_ch.func, in_ch.line_a_active, in_ch.line_b_active,
                             pred))
            begin
                if (typed_counts.size() != 0)
                begin
                    row = typed_counts.pop_front();
                    if (row.typed)
                        pred = '{count: row.count, flag: row.flag};
                end
                pending_counts.push_back(pred);
            end
        end
        if (in_acc || out_acc)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** rotary_encoder_click_decoder_top: FAILED **");
        $finish;
    end

    initial
    begin : sink_side
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send(input logic f, input logic la, input logic lb);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= f;
        in_ch.line_a_active <= la;
        in_ch.line_b_active <= lb;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic maybe_pop();
        if ($urandom_range(99) < pop_pct)
            send(recd_pkg::FUNC_POP, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Ticks needed for a rising line to commit
    function automatic int commit_hold();
        return (debounce_len == '0) ? 2 : int'(debounce_len) + 1;
    endfunction

    // One quadrature cycle per click; cw = 1 gives positive counts.
    task automatic turn(input logic cw, input int clicks, input bit clean);
        logic [1:0] pos_seq [4];
        logic [1:0] neg_seq [4];
        logic [1:0] lv;
        int         hold;
        pos_seq = '{2'b01, 2'b11, 2'b10, 2'b00};   // {a, b}
        neg_seq = '{2'b10, 2'b11, 2'b01, 2'b00};
        for (int c = 0; c < clicks; c++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                lv = cw ? pos_seq[s] : neg_seq[s];
                if (s < 2)
                    hold = clean ? commit_hold() + $urandom_range(0, 1)
                                 : $urandom_range(1, commit_hold());
                else
                    hold = $urandom_range(1, 2);
                repeat (hold)
                begin
                    maybe_pop();
                    send(recd_pkg::FUNC_TICK, lv[1], lv[0]);
                end
            end
        end
    endtask

    // Tightest clean rotation: rising lines held just long enough to commit.
    task automatic spin(input logic cw, input int clicks);
        logic [1:0] pos_seq [4];
        logic [1:0] neg_seq [4];
        logic [1:0] lv;
        int         hold;
        pos_seq = '{2'b01, 2'b11, 2'b10, 2'b00};   // {a, b}
        neg_seq = '{2'b10, 2'b11, 2'b01, 2'b00};
        for (int c = 0; c < clicks; c++)
        begin
            for (int s = 0; s < 4; s++)
            begin
                lv   = cw ? pos_seq[s] : neg_seq[s];
                hold = (s < 2) ? commit_hold() : 1;
                repeat (hold) send(recd_pkg::FUNC_TICK, lv[1], lv[0]);
            end
        end
    endtask

    task automatic noise(input int steps);
        logic la, lb;
        int   hold, cap;
        cap = (commit_hold() + 1 < 6) ? commit_hold() + 1 : 6;
        repeat (steps)
        begin
            la   = 1'($urandom_range(1));
            lb   = 1'($urandom_range(1));
            hold = $urandom_range(1, cap);
            repeat (hold)
            begin
                maybe_pop();
                send(recd_pkg::FUNC_TICK, la, lb);
            end
        end
    endtask

    task automatic wander(input int n_items);
        int stop_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at)
        begin
            case ($urandom_range(9))
                0, 1:    noise($urandom_range(2, 8));
                2:       turn(1'($urandom_range(1)), $urandom_range(1, 3), 1'b0);
                default: turn(1'($urandom_range(1)), $urandom_range(1, 6), 1'b1);
            endcase
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        // clicks from trailing ticks may still sit in the command queue
        repeat (8) @(posedge clk);
    endtask

    task automatic load_debounce(input logic [recd_pkg::CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        debounce_len = v;
    endtask

    task automatic phase_setup(input logic [recd_pkg::CFG_W-1:0] deb, input int src,
                               input int sink);
        settle();
        load_debounce(deb);
        src_idle_pct   = src;
        sink_stall_pct = sink;
    endtask

    initial
    begin : stimulus
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_ch.valid         = 1'b0;
        in_ch.func          = recd_pkg::FUNC_TICK;
        in_ch.line_a_active = 1'b0;
        in_ch.line_b_active = 1'b0;
        debounce_len = recd_pkg::DEBOUNCE_RESET;
        a_prev = 1'b0; b_prev = 1'b0; a_armed = 1'b0; b_armed = 1'b0;
        a_timer = '0; b_timer = '0;
        dir_seen = 1'b0; dir_last = 1'b0; last_from_a = 1'b0; half_step = 1'b0;
        q_head = 0; q_tail = 0; q_used = 0;
        src_idle_pct = 0; sink_stall_pct = 0; pop_pct = 0;
        hold_left = 0; quiet_cycles = 0;
        sent_items = 0; accepted_items = 0; pops_checked = 0; fails = 0; overflows = 0;
        max_seen = 0; min_seen = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_debounce(16'd1);
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].func == recd_pkg::FUNC_POP)
                typed_counts.push_back(DIRECTED[i]);
            send(DIRECTED[i].func, DIRECTED[i].line_a, DIRECTED[i].line_b);
        end

        // a long spin drives the newest entry into the upper saturation limit
        phase_setup(16'd1, 0, 0);
        spin(1'b1, 130);
        repeat (3) send(recd_pkg::FUNC_POP, 1'b1, 1'b0);

        phase_setup(16'd0, 67, 0);
        turn(1'b0, 6, 1'b1);
        repeat (3) send(recd_pkg::FUNC_POP, 1'b0, 1'b1);

        phase_setup(16'd2, 0, 67);
        pop_pct = 15;
        wander(80);

        phase_setup(16'd3, 19, 19);
        wander(80);

        phase_setup(16'hFFFF, 0, 0);
        pop_pct = 20;
        noise(12);

        // alternating single clicks never merge, so the queue overflows
        phase_setup(16'd1, 0, 0);
        pop_pct = 0;
        for (int k = 0; k < 18; k++)
            turn(1'(k % 2), 1, 1'b1);
        repeat (18)
            send(recd_pkg::FUNC_POP, 1'($urandom_range(1)), 1'($urandom_range(1)));

        // receiver holds off while pops keep coming: input must back up
        phase_setup(16'd1, 0, 0);
        hold_left <= HOLD_CYCLES;
        repeat (60)
        begin
            if ($urandom_range(1))
                send(recd_pkg::FUNC_POP, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send(recd_pkg::FUNC_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        pop_pct        = 15;
        sink_stall_pct = 19;
        src_idle_pct   = 19;
        wander(50);

        settle();
        $display("Accepted %0d items, checked %0d pop results, counts from %0d to %0d.",
                 accepted_items, pops_checked, min_seen, max_seen);
        $display("Debounce 0/1/2/3/65535, %0d queue overflows, hold-off of %0d cycles.",
                 overflows, HOLD_CYCLES);
        if (fails == 0)
            $display("** rotary_encoder_click_decoder_top: PASSED **");
        else
            $display("** rotary_encoder_click_decoder_top: FAILED **");
        $finish;
    end

endmodule
